@@ rtl/qxmd_pkg.sv @@
// ----------------------------------------------------------------------------
// qxmd_pkg: shared types and constants for the X-frame motor mixer
// Field widths, internal arithmetic widths, register indexes and the
// configuration bundle passed from the top level to the mixing core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qxmd_pkg;

    localparam int FRACTION_BITS_DEFAULT = 14;

    localparam int REG_W    = 15;
    localparam int THRUST_W = 15;
    localparam int TORQUE_W = 16;
    localparam int MOTOR_W  = 15;

    // Four-term sums of the input fields fit in 19 bits signed; one bit spare.
    localparam int SUM_W   = 20;
    // A sum plus the common shift.
    localparam int SHIFT_W = SUM_W + 1;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 64;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_YAW_TORQUE_LIMIT = 2'd0,
        REG_MOTOR_FLOOR      = 2'd1,
        REG_MOTOR_CEILING    = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [REG_W-1:0] yaw_torque_limit;
        logic [REG_W-1:0] motor_floor;
        logic [REG_W-1:0] motor_ceiling;
    } mix_cfg_t;

endpackage

@@ rtl/qxmd_core.sv @@
// ----------------------------------------------------------------------------
// qxmd_core: combinational mixing and desaturation
// Clamps yaw, forms the four X-frame sums, finds their extremes, applies the
// common shift and clamps each motor between floor and ceiling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qxmd_core (
    input  qxmd_pkg::mix_cfg_t                   cfg,
    input  logic                                 motors_off,
    input  logic        [qxmd_pkg::THRUST_W-1:0] thrust,
    input  logic signed [qxmd_pkg::TORQUE_W-1:0] torque_roll,
    input  logic signed [qxmd_pkg::TORQUE_W-1:0] torque_pitch,
    input  logic signed [qxmd_pkg::TORQUE_W-1:0] torque_yaw,
    output logic        [qxmd_pkg::MOTOR_W-1:0]  motor_front_right,
    output logic        [qxmd_pkg::MOTOR_W-1:0]  motor_back_right,
    output logic        [qxmd_pkg::MOTOR_W-1:0]  motor_back_left,
    output logic        [qxmd_pkg::MOTOR_W-1:0]  motor_front_left
);

    localparam int SW  = qxmd_pkg::SUM_W;
    localparam int XW  = qxmd_pkg::SHIFT_W;
    localparam int RW  = qxmd_pkg::REG_W;
    localparam int TW  = qxmd_pkg::TORQUE_W;
    localparam int MW  = qxmd_pkg::MOTOR_W;

    logic signed [SW-1:0] t_s;
    logic signed [SW-1:0] tx_s;
    logic signed [SW-1:0] ty_s;
    logic signed [SW-1:0] tz_raw;
    logic signed [SW-1:0] tz_s;
    logic signed [SW-1:0] lim_s;
    logic signed [SW-1:0] m_s [4];
    logic signed [SW-1:0] mn_01;
    logic signed [SW-1:0] mn_23;
    logic signed [SW-1:0] mx_01;
    logic signed [SW-1:0] mx_23;
    logic signed [SW-1:0] mn_s;
    logic signed [SW-1:0] mx_s;
    logic signed [XW-1:0] lo_x;
    logic signed [XW-1:0] hi_x;
    logic signed [XW-1:0] lift_x;
    logic signed [XW-1:0] shift_x;
    logic signed [XW-1:0] v_x    [4];
    logic        [MW-1:0] res    [4];

    always_comb
    begin
        t_s    = $signed({{(SW-qxmd_pkg::THRUST_W){1'b0}}, thrust});
        tx_s   = $signed({{(SW-TW){torque_roll[TW-1]}}, torque_roll});
        ty_s   = $signed({{(SW-TW){torque_pitch[TW-1]}}, torque_pitch});
        tz_raw = $signed({{(SW-TW){torque_yaw[TW-1]}}, torque_yaw});
        lim_s  = $signed({{(SW-RW){1'b0}}, cfg.yaw_torque_limit});

        if (tz_raw < -lim_s)
        begin
            tz_s = -lim_s;
        end
        else if (tz_raw > lim_s)
        begin
            tz_s = lim_s;
        end
        else
        begin
            tz_s = tz_raw;
        end

        m_s[0] = t_s - tx_s - ty_s - tz_s;
        m_s[1] = t_s - tx_s + ty_s + tz_s;
        m_s[2] = t_s + tx_s + ty_s - tz_s;
        m_s[3] = t_s + tx_s - ty_s + tz_s;

        mn_01 = (m_s[1] < m_s[0]) ? m_s[1] : m_s[0];
        mn_23 = (m_s[3] < m_s[2]) ? m_s[3] : m_s[2];
        mx_01 = (m_s[1] > m_s[0]) ? m_s[1] : m_s[0];
        mx_23 = (m_s[3] > m_s[2]) ? m_s[3] : m_s[2];
        mn_s  = (mn_23 < mn_01) ? mn_23 : mn_01;
        mx_s  = (mx_23 > mx_01) ? mx_23 : mx_01;

        lo_x = $signed({{(XW-RW){1'b0}}, cfg.motor_floor});
        hi_x = $signed({{(XW-RW){1'b0}}, cfg.motor_ceiling});

        // Lift the set to zero, unless that pushes the top past the ceiling.
        lift_x = (mn_s < 0) ? -$signed({mn_s[SW-1], mn_s}) : '0;
        if ($signed({mx_s[SW-1], mx_s}) + lift_x > hi_x)
        begin
            shift_x = hi_x - $signed({mx_s[SW-1], mx_s});
        end
        else
        begin
            shift_x = lift_x;
        end

        for (int i = 0; i < 4; i++)
        begin
            v_x[i] = $signed({m_s[i][SW-1], m_s[i]}) + shift_x;
            // After motors_off, the floor is tested first, so it wins when set above the ceiling.
            if (motors_off)
            begin
                res[i] = '0;
            end
            else if (v_x[i] < lo_x)
            begin
                res[i] = cfg.motor_floor;
            end
            else if (v_x[i] > hi_x)
            begin
                res[i] = cfg.motor_ceiling;
            end
            else
            begin
                res[i] = v_x[i][MW-1:0];
            end
        end

        motor_front_right = res[0];
        motor_back_right  = res[1];
        motor_back_left   = res[2];
        motor_front_left  = res[3];
    end

endmodule

@@ rtl/quad_x_motor_mixer_desaturate.sv @@
// ----------------------------------------------------------------------------
// quad_x_motor_mixer_desaturate: X-frame quadcopter mixer with desaturation
// Mixes thrust and roll, pitch and yaw torques into four motor commands.
// ----------------------------------------------------------------------------
// Path: an accepted input word passes an input register, then a result register.
// Throughput: one word per cycle while m_tready holds; an input register and a result register
// each advance whenever the stage after them is empty or being drained.
// Reset: valid flags clear and the configuration registers load 0.25, 0.04
// and 1.0 in the fixed-point format set by FRACTION_BITS.
`timescale 1ns / 1ps

module quad_x_motor_mixer_desaturate #(
    parameter int FRACTION_BITS = qxmd_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_we,
    input  logic [qxmd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [qxmd_pkg::REG_W-1:0]           cfg_data,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // Bits from low up: thrust[14:0], torque_roll[30:15], torque_pitch[46:31],
    // torque_yaw[62:47], zero fill[63].
    input  logic [qxmd_pkg::IN_TDATA_W-1:0]      s_tdata,
    // Bits: motors_off.
    input  logic                                 s_tuser,

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // Bits from low up: motor_front_right[14:0], motor_back_right[29:15],
    // motor_back_left[44:30], motor_front_left[59:45], zero fill[63:60].
    output logic [qxmd_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int RW = qxmd_pkg::REG_W;
    localparam int TW = qxmd_pkg::TORQUE_W;
    localparam int HW = qxmd_pkg::THRUST_W;
    localparam int MW = qxmd_pkg::MOTOR_W;

    localparam logic [63:0] ONE_FULL   = 64'd1 << FRACTION_BITS;
    localparam logic [63:0] YAW_FULL   = ONE_FULL / 4;
    localparam logic [63:0] FLOOR_FULL = (ONE_FULL * 4) / 100;
    localparam logic [RW-1:0] RST_YAW_LIMIT = YAW_FULL[RW-1:0];
    localparam logic [RW-1:0] RST_FLOOR     = FLOOR_FULL[RW-1:0];
    localparam logic [RW-1:0] RST_CEILING   = ONE_FULL[RW-1:0];

    qxmd_pkg::mix_cfg_t cfg_reg;

    logic                 in_valid_reg;
    logic                 off_reg;
    logic        [HW-1:0] thrust_reg;
    logic signed [TW-1:0] roll_reg;
    logic signed [TW-1:0] pitch_reg;
    logic signed [TW-1:0] yaw_reg;

    logic                 out_valid_reg;
    logic [qxmd_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic [qxmd_pkg::OUT_TDATA_W-1:0] out_data_next;

    logic                 out_en;
    logic                 in_en;
    logic        [MW-1:0] mfr;
    logic        [MW-1:0] mbr;
    logic        [MW-1:0] mbl;
    logic        [MW-1:0] mfl;

    assign out_en   = !out_valid_reg || m_tready;
    assign in_en    = !in_valid_reg || out_en;
    assign s_tready = in_en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.yaw_torque_limit <= RST_YAW_LIMIT;
            cfg_reg.motor_floor      <= RST_FLOOR;
            cfg_reg.motor_ceiling    <= RST_CEILING;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                qxmd_pkg::REG_YAW_TORQUE_LIMIT: cfg_reg.yaw_torque_limit <= cfg_data;
                qxmd_pkg::REG_MOTOR_FLOOR:      cfg_reg.motor_floor      <= cfg_data;
                qxmd_pkg::REG_MOTOR_CEILING:    cfg_reg.motor_ceiling    <= cfg_data;
                default:                        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_en)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_en)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_en && s_tvalid)
        begin
            off_reg    <= s_tuser;
            thrust_reg <= s_tdata[HW-1:0];
            roll_reg   <= s_tdata[HW+TW-1:HW];
            pitch_reg  <= s_tdata[HW+2*TW-1:HW+TW];
            yaw_reg    <= s_tdata[HW+3*TW-1:HW+2*TW];
        end
        if (out_en && in_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    qxmd_core u_core (
        .cfg               (cfg_reg),
        .motors_off        (off_reg),
        .thrust            (thrust_reg),
        .torque_roll       (roll_reg),
        .torque_pitch      (pitch_reg),
        .torque_yaw        (yaw_reg),
        .motor_front_right (mfr),
        .motor_back_right  (mbr),
        .motor_back_left   (mbl),
        .motor_front_left  (mfl)
    );

    assign out_data_next = {{(qxmd_pkg::OUT_TDATA_W-4*MW){1'b0}}, mfl, mbl, mbr, mfr};

endmodule
